// File: rtl/rfc3339_timestamp_to_epoch_assert.svh
// Assertion helpers shared by the timestamp converter.
// Both forms sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef RFC3339_TIMESTAMP_TO_EPOCH_ASSERT_SVH
`define RFC3339_TIMESTAMP_TO_EPOCH_ASSERT_SVH

// Same-cycle implication.
`define RTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rte_pkg.sv
package rte_pkg;

  // Parsed fields of one timestamp, handed from the parser to the sequencer
  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  zone_hour;
    logic [5:0]  zone_minute;
    logic        zone_negative;
  } rte_fields_t;

  // One multiply-accumulate command: acc = (clear ? 0 : acc) + a * b
  typedef struct packed {
    logic               clear;
    logic signed [23:0] a;
    logic signed [17:0] b;
  } rte_mac_op_t;

  localparam int unsigned SecW = 39;

  // Day of a March-based year on which each calendar month begins
  function automatic logic [8:0] doy_of_month(input logic [3:0] month);
    logic [8:0] doy;
    unique case (month)
      4'd3:    doy = 9'd0;
      4'd4:    doy = 9'd31;
      4'd5:    doy = 9'd61;
      4'd6:    doy = 9'd92;
      4'd7:    doy = 9'd122;
      4'd8:    doy = 9'd153;
      4'd9:    doy = 9'd184;
      4'd10:   doy = 9'd214;
      4'd11:   doy = 9'd245;
      4'd12:   doy = 9'd275;
      4'd1:    doy = 9'd306;
      4'd2:    doy = 9'd337;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

// File: rtl/rfc3339_timestamp_to_epoch.sv
// Sequencing: after the last character the sequencer counts 400-year eras and then
//   centuries by repeated subtraction and runs the eleven multiply-accumulate steps
//   before it loads the output register; a rejected string goes straight to that load.
// Throughput: one character per cycle; the input stalls from the last character until
//   the sequencer has moved its result into the output register.
// Reset: synchronous, active low; clears the parser, the sequencer and the output valid.
`include "rfc3339_timestamp_to_epoch_assert.svh"

module rfc3339_timestamp_to_epoch
  import rte_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_char_byte,
  input  logic                   in_is_final,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_ok,
  output logic signed [SecW-1:0] out_unix_seconds
);

  logic                   accept;
  logic                   start;
  logic                   busy;
  rte_fields_t            fields;
  logic                   mac_en;
  rte_mac_op_t            mac_op;
  logic signed [SecW-1:0] acc;

  // Take a request whenever the sequencer is free
  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;

  rte_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_byte (in_char_byte),
    .is_final  (in_is_final),
    .start     (start),
    .fields    (fields)
  );

  rte_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .fields           (fields),
    .busy             (busy),
    .mac_en           (mac_en),
    .mac_op           (mac_op),
    .acc              (acc),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_unix_seconds (out_unix_seconds)
  );

  rte_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .op  (mac_op),
    .acc (acc)
  );

  // The last character of a string always starts the sequencer
  `RTE_ASSERT_NEXT(a_final_starts_seq, in_valid && !in_stall && in_is_final, in_stall, "final request did not start the sequencer")

  // A rejected string reports zero seconds
  `RTE_ASSERT_NOW(a_bad_is_zero, out_valid && !out_ok, out_unix_seconds == '0, "failed result carries nonzero seconds")

endmodule

// File: rtl/rte_mac.sv
module rte_mac
  import rte_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  rte_mac_op_t            op,
  output logic signed [SecW-1:0] acc
);

  logic signed [SecW-1:0] acc_r;
  logic signed [SecW-1:0] acc_nxt;
  logic signed [41:0]     prod;

  // Multiply and fold into the accumulator
  always_comb begin
    prod    = op.a * op.b;
    acc_nxt = (op.clear ? '0 : acc_r) + $signed(prod[SecW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// File: rtl/rte_parse.sv
module rte_parse
  import rte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  char_byte,
  input  logic        is_final,
  output logic        start,
  output rte_fields_t fields
);

  localparam logic [4:0] PH_Y0    = 5'd0;
  localparam logic [4:0] PH_Y1    = 5'd1;
  localparam logic [4:0] PH_Y2    = 5'd2;
  localparam logic [4:0] PH_Y3    = 5'd3;
  localparam logic [4:0] PH_DASH1 = 5'd4;
  localparam logic [4:0] PH_MON0  = 5'd5;
  localparam logic [4:0] PH_MON1  = 5'd6;
  localparam logic [4:0] PH_DASH2 = 5'd7;
  localparam logic [4:0] PH_DAY0  = 5'd8;
  localparam logic [4:0] PH_DAY1  = 5'd9;
  localparam logic [4:0] PH_SEP   = 5'd10;
  localparam logic [4:0] PH_HR0   = 5'd11;
  localparam logic [4:0] PH_HR1   = 5'd12;
  localparam logic [4:0] PH_COL1  = 5'd13;
  localparam logic [4:0] PH_MIN0  = 5'd14;
  localparam logic [4:0] PH_MIN1  = 5'd15;
  localparam logic [4:0] PH_COL2  = 5'd16;
  localparam logic [4:0] PH_SEC0  = 5'd17;
  localparam logic [4:0] PH_SEC1  = 5'd18;
  localparam logic [4:0] PH_FRAC  = 5'd19;
  localparam logic [4:0] PH_FDIG  = 5'd20;
  localparam logic [4:0] PH_FMORE = 5'd21;
  localparam logic [4:0] PH_ZH0   = 5'd22;
  localparam logic [4:0] PH_ZH1   = 5'd23;
  localparam logic [4:0] PH_COL3  = 5'd24;
  localparam logic [4:0] PH_ZM0   = 5'd25;
  localparam logic [4:0] PH_ZM1   = 5'd26;
  localparam logic [4:0] PH_DONE  = 5'd27;

  logic [4:0]  phase_r, phase_nxt;
  logic [13:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [4:0]  zh_r, zh_nxt;
  logic [5:0]  zm_r, zm_nxt;
  logic        zneg_r, zneg_nxt;
  logic        failed_r, failed_nxt;

  logic       dig;
  logic [3:0] d;
  logic [3:0] tens;
  logic [6:0] v;
  logic [6:0] lo;
  logic [6:0] hi;
  logic       in_range;
  logic       zone_z;
  logic       zone_sign;

  // Classify the byte and form the two-digit value
  always_comb begin
    dig       = (char_byte >= "0") && (char_byte <= "9");
    d         = dig ? char_byte[3:0] : 4'd0;
    zone_z    = (char_byte == "Z") || (char_byte == "z");
    zone_sign = (char_byte == "+") || (char_byte == "-");
    unique case (phase_r)
      PH_MON1: tens = month_r;
      PH_DAY1: tens = day_r[3:0];
      PH_HR1:  tens = hour_r[3:0];
      PH_MIN1: tens = minute_r[3:0];
      PH_SEC1: tens = second_r[3:0];
      PH_ZH1:  tens = zh_r[3:0];
      default: tens = zm_r[3:0];
    endcase
    v = 7'(tens) * 7'd10 + 7'(d);
    unique case (phase_r)
      PH_MON1: begin lo = 7'd1; hi = 7'd12; end
      PH_DAY1: begin lo = 7'd1; hi = 7'd31; end
      PH_HR1:  begin lo = 7'd0; hi = 7'd23; end
      PH_ZH1:  begin lo = 7'd0; hi = 7'd23; end
      PH_SEC1: begin lo = 7'd0; hi = 7'd60; end
      default: begin lo = 7'd0; hi = 7'd59; end
    endcase
    in_range = (v >= lo) && (v <= hi);
  end

  // Advance the parse by one character
  always_comb begin
    phase_nxt  = phase_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    zh_nxt     = zh_r;
    zm_nxt     = zm_r;
    zneg_nxt   = zneg_r;
    failed_nxt = failed_r;
    if (!failed_r) begin
      unique case (phase_r)
        PH_Y0, PH_Y1, PH_Y2, PH_Y3: begin
          if (dig) begin
            year_nxt  = 14'(year_r * 14'd10) + 14'(d);
            phase_nxt = phase_r + 5'd1;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_DASH1, PH_DASH2: begin
          if (char_byte == "-") phase_nxt = phase_r + 5'd1;
          else failed_nxt = 1'b1;
        end
        PH_SEP: begin
          if (char_byte == "T") phase_nxt = phase_r + 5'd1;
          else failed_nxt = 1'b1;
        end
        PH_COL1, PH_COL2, PH_COL3: begin
          if (char_byte == ":") phase_nxt = phase_r + 5'd1;
          else failed_nxt = 1'b1;
        end
        PH_MON0, PH_DAY0, PH_HR0, PH_MIN0, PH_SEC0, PH_ZH0, PH_ZM0: begin
          if (dig) begin
            phase_nxt = phase_r + 5'd1;
            unique case (phase_r)
              PH_MON0: month_nxt  = d;
              PH_DAY0: day_nxt    = 5'(d);
              PH_HR0:  hour_nxt   = 5'(d);
              PH_MIN0: minute_nxt = 6'(d);
              PH_SEC0: second_nxt = 6'(d);
              PH_ZH0:  zh_nxt     = 5'(d);
              default: zm_nxt     = 6'(d);
            endcase
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_MON1, PH_DAY1, PH_HR1, PH_MIN1, PH_SEC1, PH_ZH1, PH_ZM1: begin
          if (!dig || !in_range) begin
            failed_nxt = 1'b1;
          end else begin
            phase_nxt = (phase_r == PH_ZM1) ? PH_DONE : phase_r + 5'd1;
            unique case (phase_r)
              PH_MON1: month_nxt  = v[3:0];
              PH_DAY1: day_nxt    = v[4:0];
              PH_HR1:  hour_nxt   = v[4:0];
              PH_MIN1: minute_nxt = v[5:0];
              PH_SEC1: second_nxt = v[5:0];
              PH_ZH1:  zh_nxt     = v[4:0];
              default: zm_nxt     = v[5:0];
            endcase
          end
        end
        PH_FRAC, PH_FMORE: begin
          if (phase_r == PH_FRAC && char_byte == ".") begin
            phase_nxt = PH_FDIG;
          end else if (phase_r == PH_FMORE && dig) begin
            phase_nxt = PH_FMORE;
          end else if (zone_z) begin
            phase_nxt = PH_DONE;
          end else if (zone_sign) begin
            zneg_nxt  = (char_byte == "-");
            phase_nxt = PH_ZH0;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_FDIG: begin
          if (dig) phase_nxt = PH_FMORE;
          else failed_nxt = 1'b1;
        end
        default: failed_nxt = 1'b1;
      endcase
    end
  end

  // Hand the finished string to the sequencer
  always_comb begin
    start                = accept && is_final;
    fields.ok            = !failed_nxt && (phase_nxt == PH_DONE);
    fields.year          = year_nxt;
    fields.month         = month_nxt;
    fields.day           = day_nxt;
    fields.hour          = hour_nxt;
    fields.minute        = minute_nxt;
    fields.second        = second_nxt;
    fields.zone_hour     = zh_nxt;
    fields.zone_minute   = zm_nxt;
    fields.zone_negative = zneg_nxt;
  end

  // Hold state between characters; clear it after the last one
  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      phase_r  <= PH_Y0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      zh_r     <= '0;
      zm_r     <= '0;
      zneg_r   <= 1'b0;
      failed_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      zh_r     <= zh_nxt;
      zm_r     <= zm_nxt;
      zneg_r   <= zneg_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// File: rtl/rte_seq.sv
module rte_seq
  import rte_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  rte_fields_t            fields,
  output logic                   busy,
  output logic                   mac_en,
  output rte_mac_op_t            mac_op,
  input  logic signed [SecW-1:0] acc,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_ok,
  output logic signed [SecW-1:0] out_unix_seconds
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV400 = 3'd1;
  localparam logic [2:0] ST_DIV100 = 3'd2;
  localparam logic [2:0] ST_MAC    = 3'd3;
  localparam logic [2:0] ST_HOLD   = 3'd4;

  localparam logic [3:0] MS_ERA   = 4'd0;
  localparam logic [3:0] MS_YOE   = 4'd1;
  localparam logic [3:0] MS_LEAP  = 4'd2;
  localparam logic [3:0] MS_CENT  = 4'd3;
  localparam logic [3:0] MS_DAY   = 4'd4;
  localparam logic [3:0] MS_SCALE = 4'd5;
  localparam logic [3:0] MS_HOUR  = 4'd6;
  localparam logic [3:0] MS_MIN   = 4'd7;
  localparam logic [3:0] MS_SEC   = 4'd8;
  localparam logic [3:0] MS_ZH    = 4'd9;
  localparam logic [3:0] MS_ZM    = 4'd10;

  // 719468 + 146097 days to the epoch, plus one for the first of the month
  localparam logic [23:0] DayBias = 24'd865566;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [4:0]  era_r, era_nxt;
  logic [1:0]  cen_r, cen_nxt;
  logic [8:0]  yoe_r, yoe_nxt;
  logic        res_ok_r, res_ok_nxt;
  rte_fields_t f_r, f_nxt;

  logic                   out_valid_r;
  logic                   out_ok_r;
  logic signed [SecW-1:0] out_sec_r;
  logic                   out_free;

  logic [13:0] divisor;
  logic        ge;

  assign out_free = !out_valid_r || !out_stall;

  // Shared compare and subtract for the era and century counts
  always_comb begin
    divisor = (state_r == ST_DIV400) ? 14'd400 : 14'd100;
    ge      = rem_r >= divisor;
  end

  // Step the sequencer
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    rem_nxt    = rem_r;
    era_nxt    = era_r;
    cen_nxt    = cen_r;
    yoe_nxt    = yoe_r;
    res_ok_nxt = res_ok_r;
    f_nxt      = f_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          f_nxt      = fields;
          res_ok_nxt = fields.ok;
          rem_nxt    = fields.year + 14'd400 - 14'(fields.month <= 4'd2);
          era_nxt    = '0;
          cen_nxt    = '0;
          state_nxt  = fields.ok ? ST_DIV400 : ST_HOLD;
        end
      end
      ST_DIV400: begin
        if (ge) begin
          rem_nxt = rem_r - divisor;
          era_nxt = era_r + 5'd1;
        end else begin
          yoe_nxt   = rem_r[8:0];
          state_nxt = ST_DIV100;
        end
      end
      ST_DIV100: begin
        if (ge) begin
          rem_nxt = rem_r - divisor;
          cen_nxt = cen_r + 2'd1;
        end else begin
          step_nxt  = MS_ERA;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (step_r == MS_ZM) state_nxt = ST_HOLD;
        else step_nxt = step_r + 4'd1;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Select the multiply-accumulate command for this step
  always_comb begin
    mac_en       = (state_r == ST_MAC);
    mac_op.clear = 1'b0;
    unique case (step_r)
      MS_ERA: begin
        mac_op.clear = 1'b1;
        mac_op.a     = 24'sd146097;
        mac_op.b     = 18'(era_r);
      end
      MS_YOE: begin
        mac_op.a = 24'(yoe_r);
        mac_op.b = 18'sd365;
      end
      MS_LEAP: begin
        mac_op.a = 24'(yoe_r[8:2]);
        mac_op.b = 18'sd1;
      end
      MS_CENT: begin
        mac_op.a = 24'(cen_r);
        mac_op.b = -18'sd1;
      end
      MS_DAY: begin
        mac_op.a = 24'(doy_of_month(f_r.month)) + 24'(f_r.day) - DayBias;
        mac_op.b = 18'sd1;
      end
      MS_SCALE: begin
        mac_op.clear = 1'b1;
        mac_op.a     = acc[23:0];
        mac_op.b     = 18'sd86400;
      end
      MS_HOUR: begin
        mac_op.a = 24'(f_r.hour);
        mac_op.b = 18'sd3600;
      end
      MS_MIN: begin
        mac_op.a = 24'(f_r.minute);
        mac_op.b = 18'sd60;
      end
      MS_SEC: begin
        mac_op.a = 24'(f_r.second);
        mac_op.b = 18'sd1;
      end
      MS_ZH: begin
        mac_op.a = 24'(f_r.zone_hour);
        mac_op.b = f_r.zone_negative ? 18'sd3600 : -18'sd3600;
      end
      default: begin
        mac_op.a = 24'(f_r.zone_minute);
        mac_op.b = f_r.zone_negative ? 18'sd60 : -18'sd60;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= MS_ERA;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    era_r    <= era_nxt;
    cen_r    <= cen_nxt;
    yoe_r    <= yoe_nxt;
    res_ok_r <= res_ok_nxt;
    f_r      <= f_nxt;
  end

  // Output register: load the held result once the slot frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_HOLD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_HOLD && out_free) begin
      out_ok_r  <= res_ok_r;
      out_sec_r <= res_ok_r ? acc : '0;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_unix_seconds = out_sec_r;

endmodule

// File: tb/sv/epoch_checker.sv
`timescale 1ns / 100ps

module epoch_checker
  import rte_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             in_char_byte,
  input  logic                   in_is_final,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   out_ok,
  input  logic signed [SecW-1:0] out_unix_seconds,
  output int                     mismatch_count,
  output int                     epochs_pending
);

  localparam logic [4:0] PosDone = 5'd27;

  typedef struct {
    logic                   ok;
    logic signed [SecW-1:0] secs;
  } epoch_result_t;

  epoch_result_t expected_epochs[$];

  // Parser state of the predictor
  logic [4:0]  pos;
  logic [13:0] year_f;
  logic [3:0]  month_f;
  logic [4:0]  day_f;
  logic [4:0]  hour_f;
  logic [5:0]  minute_f;
  logic [5:0]  second_f;
  logic [4:0]  zhour_f;
  logic [5:0]  zminute_f;
  logic        zneg_f;
  logic        parse_bad;
  logic [3:0]  tens;

  function automatic void clear_parse();
    pos       = 5'd0;
    year_f    = '0;
    month_f   = '0;
    day_f     = '0;
    hour_f    = '0;
    minute_f  = '0;
    second_f  = '0;
    zhour_f   = '0;
    zminute_f = '0;
    zneg_f    = 1'b0;
    parse_bad = 1'b0;
    tens      = '0;
  endfunction

  // Open the zone: Z/z ends the string, a sign starts the offset
  function automatic void zone_begin(input logic [7:0] c);
    if (c == "Z" || c == "z") begin
      pos = PosDone;
    end else if (c == "+" || c == "-") begin
      zneg_f = (c == "-");
      pos    = 5'd22;
    end else begin
      parse_bad = 1'b1;
    end
  endfunction

  // Advance the parser by one character
  function automatic void parse_char(input logic [7:0] c);
    logic        is_digit;
    logic [3:0]  d;
    int unsigned v;
    int unsigned lo;
    int unsigned hi;
    is_digit = (c >= "0" && c <= "9");
    d        = 4'(c - "0");
    case (pos)
      0, 1, 2, 3: begin
        if (is_digit) begin
          year_f = 14'(year_f * 10 + d);
          pos++;
        end else begin
          parse_bad = 1'b1;
        end
      end
      4, 7: begin
        if (c == "-") pos++;
        else parse_bad = 1'b1;
      end
      10: begin
        if (c == "T") pos++;
        else parse_bad = 1'b1;
      end
      13, 16, 24: begin
        if (c == ":") pos++;
        else parse_bad = 1'b1;
      end
      5, 8, 11, 14, 17, 22, 25: begin
        if (is_digit) begin
          tens = d;
          pos++;
        end else begin
          parse_bad = 1'b1;
        end
      end
      6, 9, 12, 15, 18, 23, 26: begin
        if (!is_digit) begin
          parse_bad = 1'b1;
        end else begin
          v  = tens * 10 + d;
          lo = (pos == 6 || pos == 9) ? 1 : 0;
          case (pos)
            6:       hi = 12;
            9:       hi = 31;
            12, 23:  hi = 23;
            18:      hi = 60;
            default: hi = 59;
          endcase
          if (v < lo || v > hi) begin
            parse_bad = 1'b1;
          end else begin
            case (pos)
              6:       month_f   = 4'(v);
              9:       day_f     = 5'(v);
              12:      hour_f    = 5'(v);
              15:      minute_f  = 6'(v);
              18:      second_f  = 6'(v);
              23:      zhour_f   = 5'(v);
              default: zminute_f = 6'(v);
            endcase
            pos = (pos == 5'd26) ? PosDone : pos + 5'd1;
          end
        end
      end
      19: begin
        if (c == ".") pos = 5'd20;
        else zone_begin(c);
      end
      20: begin
        if (is_digit) pos = 5'd21;
        else parse_bad = 1'b1;
      end
      21: begin
        if (!is_digit) zone_begin(c);
      end
      default: parse_bad = 1'b1;
    endcase
  endfunction

  // Civil date to Unix seconds; days past the month's end simply carry on
  function automatic longint epoch_of();
    longint y;
    longint era;
    longint yoe;
    longint doy;
    longint doe;
    longint days;
    longint t;
    longint off;
    y    = longint'(year_f) + 400 - ((month_f <= 4'd2) ? 1 : 0);
    era  = y / 400;
    yoe  = y - era * 400;
    doy  = (153 * ((longint'(month_f) + 9) % 12) + 2) / 5 + longint'(day_f) - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468 - 146097;
    t    = days * 86400 + longint'(hour_f) * 3600 + longint'(minute_f) * 60
         + longint'(second_f);
    off  = (longint'(zhour_f) * 60 + longint'(zminute_f)) * 60;
    return zneg_f ? t + off : t - off;
  endfunction

  // Compare results, then predict from the accepted request
  always @(posedge clk) begin
    epoch_result_t want;
    epoch_result_t got;
    if (!rst_n) begin
      clear_parse();
      expected_epochs.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.ok   = out_ok;
        got.secs = out_unix_seconds;
        if (expected_epochs.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result ok=%0b seconds=%0d, expected none",
                   $time, got.ok, got.secs);
        end else begin
          want = expected_epochs.pop_front();
          if (got.ok !== want.ok) begin
            mismatch_count++;
            $display("%0t: ok mismatch, expected %0b, actual %0b", $time, want.ok, got.ok);
          end
          if (got.secs !== want.secs) begin
            mismatch_count++;
            $display("%0t: unix_seconds mismatch, expected %0d, actual %0d",
                     $time, want.secs, got.secs);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (!parse_bad) parse_char(in_char_byte);
        if (in_is_final) begin
          want.ok   = 1'b0;
          want.secs = '0;
          if (!parse_bad && pos == PosDone) begin
            want.ok   = 1'b1;
            want.secs = epoch_of();
          end
          expected_epochs.insert(expected_epochs.size(), want);
          clear_parse();
        end
      end
    end
    epochs_pending = expected_epochs.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rte_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 60;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_char_byte = 8'd0;
  logic                   in_is_final = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_ok;
  logic signed [SecW-1:0] out_unix_seconds;

  int mismatch_count;
  int epochs_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int chars_sent = 0;

  logic [7:0] stamp_bytes[$];

  always #10 clk = ~clk;

  rfc3339_timestamp_to_epoch u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_is_final      (in_is_final),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_unix_seconds (out_unix_seconds)
  );

  epoch_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_is_final      (in_is_final),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_unix_seconds (out_unix_seconds),
    .mismatch_count   (mismatch_count),
    .epochs_pending   (epochs_pending)
  );

  // Randomly hold off the result channel
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Drive one character and hold it until the block takes it
  task automatic push_char(input logic [7:0] c, input logic last_char);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= c;
    in_is_final  <= last_char;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  // Append one byte to the string being assembled
  task automatic append_byte(input logic [7:0] b);
    stamp_bytes.insert(stamp_bytes.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic add_digits(input int unsigned value, input int n);
    int unsigned scale;
    scale = 1;
    repeat (n - 1) scale *= 10;
    repeat (n) begin
      append_byte(8'("0" + (value / scale) % 10));
      scale /= 10;
    end
  endtask

  // Send the assembled string, flagging its last byte
  task automatic send_stamp();
    int last_idx;
    last_idx = stamp_bytes.size() - 1;
    for (int i = 0; i <= last_idx; i++) push_char(stamp_bytes[i], i == last_idx);
    stamp_bytes.delete();
  endtask

  // Mostly in range, often at the edges, now and then any two digits
  function automatic int unsigned field_value(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return lo;
    if (r < 16) return hi;
    if (r < 90) return $urandom_range(hi, lo);
    return $urandom_range(99);
  endfunction

  // Assemble a timestamp of the right shape with random content; a field may fall out of range
  task automatic build_stamp();
    int unsigned r;
    add_digits(field_value(0, 9999), 4);
    add_text("-");
    add_digits(field_value(1, 12), 2);
    add_text("-");
    add_digits(field_value(1, 31), 2);
    add_text("T");
    add_digits(field_value(0, 23), 2);
    add_text(":");
    add_digits(field_value(0, 59), 2);
    add_text(":");
    add_digits(field_value(0, 60), 2);
    if ($urandom_range(2) == 0) begin
      add_text(".");
      repeat ($urandom_range(6, 1)) add_digits($urandom_range(9), 1);
    end
    r = $urandom_range(3);
    if (r == 0) begin
      add_text("Z");
    end else if (r == 1) begin
      add_text("z");
    end else begin
      add_text(r == 2 ? "+" : "-");
      add_digits(field_value(0, 23), 2);
      add_text(":");
      add_digits(field_value(0, 59), 2);
    end
  endtask

  // Break a string: overwrite, truncate or extend it
  task automatic corrupt_stamp();
    int unsigned idx;
    int unsigned cut;
    case ($urandom_range(3))
      0: begin
        idx = $urandom_range(stamp_bytes.size() - 1);
        stamp_bytes[idx] = 8'($urandom_range(255));
      end
      1: begin
        cut = $urandom_range(stamp_bytes.size() - 1, 1);
        while (stamp_bytes.size() > cut) stamp_bytes.delete(stamp_bytes.size() - 1);
      end
      2: begin
        if ($urandom_range(1) == 0) add_digits($urandom_range(9), 1);
        else append_byte(8'($urandom_range(255)));
      end
      default: begin
        idx = $urandom_range(stamp_bytes.size() - 1);
        stamp_bytes[idx] = 8'("0" + $urandom_range(9));
      end
    endcase
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (epochs_pending != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int char_target);
    int unsigned r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (chars_sent < char_target) begin
      r = $urandom_range(99);
      if (r < 10) begin
        repeat ($urandom_range(4, 1)) append_byte(8'($urandom_range(255)));
      end else begin
        build_stamp();
        if (r < 40) corrupt_stamp();
      end
      send_stamp();
    end
    wait_drained();
  endtask

  // Stop the run if nothing moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, rollover and each malformed shape
    add_text("0000-01-01T00:00:00Z");
    send_stamp();
    add_text("9999-12-31T23:59:60.123456789-23:59");
    send_stamp();
    add_text("9999-12-31T23:59:59+23:59");
    send_stamp();
    add_text("1970-01-01T00:00:00.5z");
    send_stamp();
    add_text("2021-02-31T12:30:45Z");
    send_stamp();
    add_text("2020-13-01T00:00:60Z");
    send_stamp();
    add_text("2020-01-01t00:00:00Z");
    send_stamp();
    add_text("2020-01-01T00:00:00.Z");
    send_stamp();
    add_text("2020-01-01T00:00:00Z5");
    send_stamp();
    add_text("2020-01-01T00:00:00+05");
    send_stamp();
    append_byte(8'hff);
    send_stamp();
    wait_drained();

    // Random: no idling, sender idle, receiver stalling, both
    run_phase(0, 0, 450);
    run_phase(57, 0, 680);
    run_phase(0, 57, 910);
    run_phase(20, 20, 1150);

    recv_stall_pct = 0;
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/rte_pkg.sv
rtl/rte_mac.sv
rtl/rte_parse.sv
rtl/rte_seq.sv
rtl/rfc3339_timestamp_to_epoch.sv
tb/sv/epoch_checker.sv
tb/sv/tb_top.sv
